@@ rtl/fdm_pkg.sv @@
// shared types, constants and the round-and-pack function for the floor divmod block
// no dependencies; used by fdm_addsub, fdm_div and float_floor_divmod
package fdm_pkg;

    typedef logic [62:0] mag_t;

    typedef struct packed {
        logic start;
        logic sub;
    } as_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_sts_t;

    localparam mag_t        MAG_INF       = 63'h7FF0_0000_0000_0000;
    localparam mag_t        ONE_MAG       = 63'h3FF0_0000_0000_0000;
    localparam mag_t        NEAR_HALF_MAG = 63'h3FDF_FFFF_FFFF_FFFF;
    localparam logic [63:0] QNAN_BITS     = 64'h7FF8_0000_0000_0000;
    localparam logic [63:0] NEG_ONE       = 64'hBFF0_0000_0000_0000;
    localparam logic [51:0] MANT52        = 52'hF_FFFF_FFFF_FFFF;
    localparam logic [10:0] EXP_ALL1      = 11'h7FF;

    // sig: hidden bit at 55, guard at 2, round and sticky below; nearest-even
    function automatic mag_t round_pack(input logic [12:0] e, input logic [55:0] sig);
        logic        up;
        logic [53:0] m54;
        logic [52:0] mant;
        logic [12:0] er;
        mag_t        res;
        up  = sig[2] & (sig[1] | sig[0] | sig[3]);
        m54 = {1'b0, sig[55:3]} + {53'd0, up};
        if (m54[53])
        begin
            mant = m54[53:1];
            er   = e + 13'd1;
        end
        else
        begin
            mant = m54[52:0];
            er   = e;
        end
        if (er >= 13'd2047)
            res = MAG_INF;
        else if (mant[52])
            res = {er[10:0], mant[51:0]};
        else
            res = {11'd0, mant[51:0]};
        return res;
    endfunction

endpackage

@@ rtl/fdm_addsub.sv @@
// serial magnitude add/subtract of two finite binary64 magnitudes, |a| >= |b|
// alignment and normalization shift one bit per cycle; depends on fdm_pkg
module fdm_addsub (
    input  logic               clk,
    input  logic               rst_n,
    input  fdm_pkg::as_cmd_t   cmd,
    input  fdm_pkg::mag_t      a,
    input  fdm_pkg::mag_t      b,
    output fdm_pkg::unit_sts_t sts,
    output fdm_pkg::mag_t      res
);
    import fdm_pkg::*;

    localparam logic [1:0] A_IDLE  = 2'd0;
    localparam logic [1:0] A_ALIGN = 2'd1;
    localparam logic [1:0] A_SUM   = 2'd2;
    localparam logic [1:0] A_NORM  = 2'd3;

    logic [1:0]  st_reg, st_next;
    logic        done_reg, done_next;
    logic        sub_reg, sub_next;
    logic [55:0] sa_reg, sa_next;
    logic [55:0] sb_reg, sb_next;
    logic [10:0] d_reg, d_next;
    logic [12:0] e_reg, e_next;
    mag_t        res_reg, res_next;

    logic [10:0] ea, eb;
    logic [56:0] sum;

    always_comb
    begin
        st_next   = st_reg;
        done_next = 1'b0;
        sub_next  = sub_reg;
        sa_next   = sa_reg;
        sb_next   = sb_reg;
        d_next    = d_reg;
        e_next    = e_reg;
        res_next  = res_reg;
        ea  = (a[62:52] != 11'd0) ? a[62:52] : 11'd1;
        eb  = (b[62:52] != 11'd0) ? b[62:52] : 11'd1;
        sum = sub_reg ? ({1'b0, sa_reg} - {1'b0, sb_reg}) : ({1'b0, sa_reg} + {1'b0, sb_reg});
        case (st_reg)
            A_IDLE:
            begin
                if (cmd.start)
                begin
                    sub_next = cmd.sub;
                    sa_next  = {a[62:52] != 11'd0, a[51:0], 3'b000};
                    sb_next  = {b[62:52] != 11'd0, b[51:0], 3'b000};
                    d_next   = ea - eb;
                    e_next   = {2'b00, ea};
                    st_next  = A_ALIGN;
                end
            end
            A_ALIGN:
            begin
                // once only the sticky bit is left, further shifts change nothing
                if (d_reg == 11'd0 || sb_reg[55:1] == 55'd0)
                    st_next = A_SUM;
                else
                begin
                    sb_next = {1'b0, sb_reg[55:2], sb_reg[1] | sb_reg[0]};
                    d_next  = d_reg - 11'd1;
                end
            end
            A_SUM:
            begin
                if (sum[56])
                begin
                    sa_next = {sum[56:2], sum[1] | sum[0]};
                    e_next  = e_reg + 13'd1;
                end
                else
                    sa_next = sum[55:0];
                st_next = A_NORM;
            end
            A_NORM:
            begin
                // stop at the subnormal exponent
                if (!sa_reg[55] && e_reg > 13'd1 && sa_reg != 56'd0)
                begin
                    sa_next = {sa_reg[54:0], 1'b0};
                    e_next  = e_reg - 13'd1;
                end
                else
                begin
                    res_next  = round_pack(e_reg, sa_reg);
                    done_next = 1'b1;
                    st_next   = A_IDLE;
                end
            end
            default: st_next = A_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= A_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sub_reg <= sub_next;
        sa_reg  <= sa_next;
        sb_reg  <= sb_next;
        d_reg   <= d_next;
        e_reg   <= e_next;
        res_reg <= res_next;
    end

    assign sts.busy = (st_reg != A_IDLE);
    assign sts.done = done_reg;
    assign res      = res_reg;

endmodule

@@ rtl/fdm_div.sv @@
// restoring divider for two finite nonzero binary64 magnitudes, one quotient bit a cycle
// result is rounded to nearest-even; depends on fdm_pkg
module fdm_div (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  fdm_pkg::mag_t      a,
    input  fdm_pkg::mag_t      b,
    output fdm_pkg::unit_sts_t sts,
    output fdm_pkg::mag_t      res
);
    import fdm_pkg::*;

    localparam logic [2:0] D_IDLE = 3'd0;
    localparam logic [2:0] D_NORM = 3'd1;
    localparam logic [2:0] D_PRE  = 3'd2;
    localparam logic [2:0] D_ITER = 3'd3;
    localparam logic [2:0] D_PACK = 3'd4;
    localparam logic [5:0] DIV_LAST = 6'd54;

    logic [2:0]  st_reg, st_next;
    logic        done_reg, done_next;
    logic [53:0] ma_reg, ma_next;
    logic [52:0] mb_reg, mb_next;
    logic [12:0] ea_reg, ea_next;
    logic [12:0] eb_reg, eb_next;
    logic [13:0] qe_reg, qe_next;
    logic [54:0] q_reg, q_next;
    logic [5:0]  cnt_reg, cnt_next;
    mag_t        res_reg, res_next;

    logic [54:0] dv;
    logic        qbit;
    logic [53:0] rem;

    always_comb
    begin
        st_next   = st_reg;
        done_next = 1'b0;
        ma_next   = ma_reg;
        mb_next   = mb_reg;
        ea_next   = ea_reg;
        eb_next   = eb_reg;
        qe_next   = qe_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        res_next  = res_reg;
        dv   = {1'b0, ma_reg} - {2'b00, mb_reg};
        qbit = !dv[54];
        rem  = qbit ? dv[53:0] : ma_reg;
        case (st_reg)
            D_IDLE:
            begin
                if (start)
                begin
                    ma_next = {1'b0, a[62:52] != 11'd0, a[51:0]};
                    mb_next = {b[62:52] != 11'd0, b[51:0]};
                    ea_next = (a[62:52] != 11'd0) ? {2'b00, a[62:52]} : 13'd1;
                    eb_next = (b[62:52] != 11'd0) ? {2'b00, b[62:52]} : 13'd1;
                    st_next = D_NORM;
                end
            end
            D_NORM:
            begin
                if (ma_reg[52] && mb_reg[52])
                    st_next = D_PRE;
                if (!ma_reg[52])
                begin
                    ma_next = {ma_reg[52:0], 1'b0};
                    ea_next = ea_reg - 13'd1;
                end
                if (!mb_reg[52])
                begin
                    mb_next = {mb_reg[51:0], 1'b0};
                    eb_next = eb_reg - 13'd1;
                end
            end
            D_PRE:
            begin
                // bring the dividend to at least the divisor so the leading bit is one
                if (ma_reg[52:0] < mb_reg)
                begin
                    ma_next = {ma_reg[52:0], 1'b0};
                    qe_next = {ea_reg[12], ea_reg} - {eb_reg[12], eb_reg} + 14'd1022;
                end
                else
                    qe_next = {ea_reg[12], ea_reg} - {eb_reg[12], eb_reg} + 14'd1023;
                cnt_next = 6'd0;
                st_next  = D_ITER;
            end
            D_ITER:
            begin
                q_next   = {q_reg[53:0], qbit};
                ma_next  = {rem[52:0], 1'b0};
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == DIV_LAST)
                    st_next = D_PACK;
            end
            D_PACK:
            begin
                res_next  = round_pack(qe_reg[12:0], {q_reg, ma_reg != 54'd0});
                done_next = 1'b1;
                st_next   = D_IDLE;
            end
            default: st_next = D_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= D_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ma_reg  <= ma_next;
        mb_reg  <= mb_next;
        ea_reg  <= ea_next;
        eb_reg  <= eb_next;
        qe_reg  <= qe_next;
        q_reg   <= q_next;
        cnt_reg <= cnt_next;
        res_reg <= res_next;
    end

    assign sts.busy = (st_reg != D_IDLE);
    assign sts.done = done_reg;
    assign res      = res_reg;

endmodule

@@ rtl/float_floor_divmod.sv @@
// top level: binary64 floor quotient and remainder with the remainder signed like the divisor
// uses fdm_pkg, fdm_addsub (serial add/subtract) and fdm_div (serial divider)
//
// channel  signals                                          beat taken when
// in       start, dividend_bits, divisor_bits               start high, busy low
// out      done, quotient_bits, remainder_bits, zero_divide done high, one cycle only
//
// a zero divisor or nan ends right at classification; otherwise the operands may be normalized
// and the exact fmod loop run, one exponent step per cycle, from ex down to ey; then up to three
// add/subtract passes and the divide follow as needed
// reset clears only the state register and done; busy stays high until the result beat
// the result beat cannot be stalled and a new start may come in that same cycle
module float_floor_divmod (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [63:0] dividend_bits,
    input  logic [63:0] divisor_bits,
    output logic        done,
    output logic [63:0] quotient_bits,
    output logic [63:0] remainder_bits,
    output logic        zero_divide
);
    import fdm_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CLASS = 4'd1;
    localparam logic [3:0] S_XNORM = 4'd2;
    localparam logic [3:0] S_FMOD  = 4'd3;
    localparam logic [3:0] S_FNORM = 4'd4;
    localparam logic [3:0] S_FDEN  = 4'd5;
    localparam logic [3:0] S_DIFF  = 4'd6;
    localparam logic [3:0] S_DIFFW = 4'd7;
    localparam logic [3:0] S_DIVGO = 4'd8;
    localparam logic [3:0] S_DIVW  = 4'd9;
    localparam logic [3:0] S_FIX   = 4'd10;
    localparam logic [3:0] S_MODW  = 4'd11;
    localparam logic [3:0] S_FIX2  = 4'd12;
    localparam logic [3:0] S_DADJW = 4'd13;
    localparam logic [3:0] S_QRND  = 4'd14;

    logic [3:0]         st_reg, st_next;
    logic               done_reg, done_next;
    logic [63:0]        x_reg, x_next;
    logic [63:0]        y_reg, y_next;
    logic [53:0]        ux_reg, ux_next;
    logic [52:0]        uy_reg, uy_next;
    logic signed [12:0] ex_reg, ex_next;
    logic signed [12:0] ey_reg, ey_next;
    logic [63:0]        mod_reg, mod_next;
    logic [63:0]        div_reg, div_next;
    logic               divz_reg, divz_next;
    logic [63:0]        q_reg, q_next;
    logic [63:0]        r_reg, r_next;
    logic               zd_reg, zd_next;

    mag_t        x_mag, y_mag;
    logic        sx, sy, y_zero, op_nan, y_inf, div_inf, mod_nz, adjust;
    logic [54:0] fm_diff;
    logic        fm_ge, fm_zero;

    as_cmd_t   as_cmd;
    mag_t      as_a, as_b, as_res;
    unit_sts_t as_sts;
    logic      dv_start;
    mag_t      dv_res;
    unit_sts_t dv_sts;

    // nearest integral value with halves going toward minus infinity, as truncation of the magnitude then a bump
    function automatic logic [63:0] q_round(input logic [63:0] u);
        logic [10:0] f;
        logic [10:0] f_off;
        logic [51:0] m, frac, half;
        logic        up;
        logic [63:0] res;
        f     = u[62:52];
        f_off = f - 11'd1023;
        m     = MANT52 >> f_off[5:0];
        frac  = u[51:0] & m;
        half  = (m >> 1) + 52'd1;
        up    = u[63] ? (frac >= half) : (frac > half);
        if (f >= 11'd1075)
            res = u;
        else if (f < 11'd1023)
        begin
            // one below the half has a rounded 1 - |u| that lands on the half itself
            if (!u[63])
                res = (f == 11'd1022 && u[51:0] != 52'd0) ? {1'b0, ONE_MAG} : 64'd0;
            else
                res = (f == 11'd1022 || u[62:0] == NEAR_HALF_MAG) ? NEG_ONE : 64'd0;
        end
        else
            res = {u[63:52], u[51:0] & ~m} + (up ? ({12'd0, m} + 64'd1) : 64'd0);
        return res;
    endfunction

    fdm_addsub u_addsub (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (as_cmd),
        .a     (as_a),
        .b     (as_b),
        .sts   (as_sts),
        .res   (as_res)
    );

    fdm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (dv_start),
        .a     (div_reg[62:0]),
        .b     (y_reg[62:0]),
        .sts   (dv_sts),
        .res   (dv_res)
    );

    always_comb
    begin
        x_mag   = x_reg[62:0];
        y_mag   = y_reg[62:0];
        sx      = x_reg[63];
        sy      = y_reg[63];
        y_zero  = (y_mag == 63'd0);
        op_nan  = (x_mag > MAG_INF) || (y_mag > MAG_INF) || (x_reg[62:52] == EXP_ALL1);
        y_inf   = (y_reg[62:52] == EXP_ALL1);
        div_inf = (div_reg[62:52] == EXP_ALL1);
        mod_nz  = (mod_reg[62:0] != 63'd0);
        adjust  = mod_nz && (mod_reg[63] != sy);
        fm_diff = {1'b0, ux_reg} - {2'b00, uy_reg};
        fm_ge   = !fm_diff[54];
        fm_zero = (fm_diff[53:0] == 54'd0);

        as_cmd.start = 1'b0;
        as_cmd.sub   = 1'b1;
        as_a         = y_mag;
        as_b         = mod_reg[62:0];
        dv_start     = 1'b0;
        case (st_reg)
            S_DIFF:
            begin
                as_a         = x_mag;
                as_cmd.start = mod_nz;
            end
            S_FIX:   as_cmd.start = adjust && !y_inf;
            S_FIX2:
            begin
                as_a         = div_reg[62:0];
                as_b         = ONE_MAG;
                as_cmd.sub   = 1'b0;
                as_cmd.start = !divz_reg && !div_inf;
            end
            S_DIVGO: dv_start = 1'b1;
            default: as_cmd.start = 1'b0;
        endcase

        st_next   = st_reg;
        done_next = 1'b0;
        x_next    = x_reg;
        y_next    = y_reg;
        ux_next   = ux_reg;
        uy_next   = uy_reg;
        ex_next   = ex_reg;
        ey_next   = ey_reg;
        mod_next  = mod_reg;
        div_next  = div_reg;
        divz_next = divz_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        zd_next   = zd_reg;
        case (st_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    x_next  = dividend_bits;
                    y_next  = divisor_bits;
                    st_next = S_CLASS;
                end
            end
            S_CLASS:
            begin
                divz_next = 1'b0;
                ux_next   = {1'b0, x_reg[62:52] != 11'd0, x_reg[51:0]};
                uy_next   = {y_reg[62:52] != 11'd0, y_reg[51:0]};
                ex_next   = (x_reg[62:52] != 11'd0) ? $signed({2'b00, x_reg[62:52]}) : 13'sd1;
                ey_next   = (y_reg[62:52] != 11'd0) ? $signed({2'b00, y_reg[62:52]}) : 13'sd1;
                if (y_zero)
                begin
                    q_next    = 64'd0;
                    r_next    = 64'd0;
                    zd_next   = 1'b1;
                    done_next = 1'b1;
                    st_next   = S_IDLE;
                end
                else if (op_nan)
                begin
                    q_next    = QNAN_BITS;
                    r_next    = QNAN_BITS;
                    zd_next   = 1'b0;
                    done_next = 1'b1;
                    st_next   = S_IDLE;
                end
                else if (x_mag < y_mag)
                begin
                    // remainder is the dividend, quotient before the fix is zero
                    mod_next  = x_reg;
                    divz_next = 1'b1;
                    st_next   = S_FIX;
                end
                else if (x_mag == y_mag)
                begin
                    mod_next = {sx, 63'd0};
                    div_next = x_reg;
                    st_next  = S_DIVGO;
                end
                else
                    st_next = S_XNORM;
            end
            S_XNORM:
            begin
                if (ux_reg[52] && uy_reg[52])
                    st_next = S_FMOD;
                if (!ux_reg[52])
                begin
                    ux_next = {ux_reg[52:0], 1'b0};
                    ex_next = ex_reg - 13'sd1;
                end
                if (!uy_reg[52])
                begin
                    uy_next = {uy_reg[51:0], 1'b0};
                    ey_next = ey_reg - 13'sd1;
                end
            end
            S_FMOD:
            begin
                if (fm_ge && fm_zero)
                begin
                    mod_next = {sx, 63'd0};
                    st_next  = S_DIFF;
                end
                else if (ex_reg > ey_reg)
                begin
                    ux_next = fm_ge ? {fm_diff[52:0], 1'b0} : {ux_reg[52:0], 1'b0};
                    ex_next = ex_reg - 13'sd1;
                end
                else
                begin
                    if (fm_ge)
                        ux_next = fm_diff[53:0];
                    st_next = S_FNORM;
                end
            end
            S_FNORM:
            begin
                if (!ux_reg[52])
                begin
                    ux_next = {ux_reg[52:0], 1'b0};
                    ex_next = ex_reg - 13'sd1;
                end
                else if (ex_reg > 13'sd0)
                begin
                    mod_next = {sx, ex_reg[10:0], ux_reg[51:0]};
                    st_next  = S_DIFF;
                end
                else
                    st_next = S_FDEN;
            end
            S_FDEN:
            begin
                // denormalize down to the subnormal exponent; exact, low bits are zero
                if (ex_reg < 13'sd1)
                begin
                    ux_next = {1'b0, ux_reg[53:1]};
                    ex_next = ex_reg + 13'sd1;
                end
                else
                begin
                    mod_next = {sx, 11'd0, ux_reg[51:0]};
                    st_next  = S_DIFF;
                end
            end
            S_DIFF:
            begin
                if (mod_nz)
                    st_next = S_DIFFW;
                else
                begin
                    div_next = x_reg;
                    st_next  = S_DIVGO;
                end
            end
            S_DIFFW:
            begin
                if (as_sts.done)
                begin
                    div_next = {sx, as_res};
                    st_next  = S_DIVGO;
                end
            end
            S_DIVGO: st_next = S_DIVW;
            S_DIVW:
            begin
                if (dv_sts.done)
                begin
                    div_next = {sx ^ sy, dv_res};
                    st_next  = S_FIX;
                end
            end
            S_FIX:
            begin
                if (adjust)
                begin
                    if (y_inf)
                    begin
                        mod_next = y_reg;
                        st_next  = S_FIX2;
                    end
                    else
                        st_next = S_MODW;
                end
                else
                begin
                    if (!mod_nz)
                        mod_next = {sy, 63'd0};
                    st_next = S_QRND;
                end
            end
            S_MODW:
            begin
                if (as_sts.done)
                begin
                    mod_next = {sy, as_res};
                    st_next  = S_FIX2;
                end
            end
            S_FIX2:
            begin
                if (divz_reg)
                begin
                    div_next  = NEG_ONE;
                    divz_next = 1'b0;
                    st_next   = S_QRND;
                end
                else if (div_inf)
                    st_next = S_QRND;
                else
                    st_next = S_DADJW;
            end
            S_DADJW:
            begin
                // quotient is negative here, so lowering by one grows the magnitude
                if (as_sts.done)
                begin
                    div_next = {div_reg[63], as_res};
                    st_next  = S_QRND;
                end
            end
            S_QRND:
            begin
                q_next    = divz_reg ? {sx ^ sy, 63'd0} : q_round(div_reg);
                r_next    = mod_reg;
                zd_next   = 1'b0;
                done_next = 1'b1;
                st_next   = S_IDLE;
            end
            default: st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= S_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        ux_reg   <= ux_next;
        uy_reg   <= uy_next;
        ex_reg   <= ex_next;
        ey_reg   <= ey_next;
        mod_reg  <= mod_next;
        div_reg  <= div_next;
        divz_reg <= divz_next;
        q_reg    <= q_next;
        r_reg    <= r_next;
        zd_reg   <= zd_next;
    end

    assign busy           = (st_reg != S_IDLE);
    assign done           = done_reg;
    assign quotient_bits  = q_reg;
    assign remainder_bits = r_reg;
    assign zero_divide    = zd_reg;

endmodule
